[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RMS meter. Clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define RMS_ASSERT_NEVER(label, cond, msg) \
  `RMS_ASSERT(label, !(cond), msg)

`endif

[src/wrms_pkg.sv]
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared constants and controller/datapath interface types of the RMS meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrms_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_SAMPLES = 4096;

  localparam int unsigned SAMPLE_W = 16;  // fixed width of the sample field
  localparam int unsigned SCALE_W  = 16;  // Q8.8 gain
  localparam int unsigned SCALE_FRAC = 8;
  localparam int unsigned RMS_W    = 24;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6400;  // 25.0
  localparam logic [RMS_W-1:0]   RMS_MAX     = {RMS_W{1'b1}};

  // request kinds on the input stream
  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept_en;  // input stream may take a request
    logic load;       // report taken: snapshot window, clear it
    logic div_step;   // one quotient bit
    logic sq_load;    // quotient into root unit
    logic sq_step;    // one root bit
    logic mul;        // root times gain
    logic out_load;   // result into output register
  } wrms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;   // window currently holds no samples
    logic out_free;   // output register can take a result this cycle
  } wrms_sts_t;

endpackage

`default_nettype wire

[src/windowed_rms_meter_unit.sv]
// ----------------------------------------------------------------------------
// windowed_rms_meter_unit
// Samples: one request per cycle while no report runs, squared and summed
//   with no stall. Report: result computed by a 1-bit/cycle divider and a
//   1-bit/cycle root unit, then scaled by the gain.
// Empty-window report: divider and root unit skipped. No input taken until
//   the result is loaded.
// Reset (async, active low): window cleared, gain back to 25.0, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_meter_unit #(
  parameter int unsigned SAMPLE_BITS = wrms_pkg::SAMPLE_BITS,  // 8..24
  parameter int unsigned MAX_SAMPLES = wrms_pkg::MAX_SAMPLES   // 2..65536
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  signed [wrms_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  input  wire  [0:0]                        s_axis_tuser,   // [0] command
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [wrms_pkg::RMS_W-1:0]        m_axis_tdata,   // [23:0] rms_value
  output logic [1:0]                        m_axis_tuser,   // [0] empty_window,
                                                            // [1] samples_dropped
  // gain register, unsigned Q8.8
  input  wire                               cfg_we_i,
  input  wire  [wrms_pkg::SCALE_W-1:0]      cfg_wdata_i
);

  // The controller owns sequencing only; every arithmetic register sits in
  // the datapath. A report request snapshots the window (including a square
  // still in flight) and clears it in the same cycle, so samples that follow
  // the result start a fresh window.
  wrms_pkg::wrms_cmd_t cmd;
  wrms_pkg::wrms_sts_t sts;
  logic                out_empty, out_dropped;

  wrms_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser[0]),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  wrms_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_command_i  (s_axis_tuser[0]),
    .in_sample_i   (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_rms_o     (m_axis_tdata),
    .out_empty_o   (out_empty),
    .out_dropped_o (out_dropped),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  assign m_axis_tuser = {out_dropped, out_empty};

endmodule

`default_nettype wire

[src/wrms_datapath.sv]
// ----------------------------------------------------------------------------
// wrms_datapath
// Squaring accumulator, bit-serial divider, digit-serial root, gain multiply
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_datapath #(
  parameter int unsigned SAMPLE_BITS = wrms_pkg::SAMPLE_BITS,
  parameter int unsigned MAX_SAMPLES = wrms_pkg::MAX_SAMPLES
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  wrms_pkg::wrms_cmd_t         cmd_i,
  output wrms_pkg::wrms_sts_t               sts_o,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               in_command_i,
  input  wire  signed [wrms_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [wrms_pkg::RMS_W-1:0]        out_rms_o,
  output logic                              out_empty_o,
  output logic                              out_dropped_o,
  input  wire                               cfg_we_i,
  input  wire  [wrms_pkg::SCALE_W-1:0]      cfg_wdata_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned RAW_W  = (SB > wrms_pkg::SAMPLE_W) ? SB : wrms_pkg::SAMPLE_W;
  localparam int unsigned SQ_W   = 2 * SB;
  localparam int unsigned SUM_W  = 2 * SB - 1 + $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SR_W   = SB + 2;
  localparam int unsigned PROD_W = SB + wrms_pkg::SCALE_W;
  localparam int unsigned HI_W   = PROD_W - wrms_pkg::SCALE_FRAC;
  localparam int unsigned CMP_W  = (HI_W > wrms_pkg::RMS_W) ? HI_W : wrms_pkg::RMS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // window state
  logic [SUM_W-1:0]  sum_q, sum_d, sum_add;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [SQ_W-1:0]   sq_q;
  logic              sq_vld_q;
  logic [wrms_pkg::SCALE_W-1:0] scale_q;

  // report datapath
  logic [CNT_W-1:0]  den_q;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SQ_W-1:0]   rad_q, rad_d;
  logic [SB-1:0]     root_q, root_d;
  logic [SR_W-1:0]   srem_q, srem_d;
  logic [PROD_W-1:0] prod_q;
  logic              empty_q, dsnap_q;

  // output register
  logic                       out_vld_q;
  logic [wrms_pkg::RMS_W-1:0] out_rms_q;
  logic                       out_empty_q, out_drop_q;

  // sample magnitude and square
  logic [RAW_W-1:0] raw;
  logic [SB-1:0]    v, mag;
  logic             acc, full;

  assign raw  = RAW_W'($unsigned(in_sample_i));
  assign v    = raw[SB-1:0];
  assign mag  = v[SB-1] ? (~v + SB'(1)) : v;
  assign acc  = in_valid_i && cmd_i.accept_en && (in_command_i == wrms_pkg::CMD_ACCUM);
  assign full = (cnt_q == CNT_MAX);

  assign sum_add = sum_q + (sq_vld_q ? SUM_W'(sq_q) : SUM_W'(0));

  always_comb begin
    sum_d  = sq_vld_q ? sum_add : sum_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (acc && full) begin
      drop_d = 1'b1;
    end else if (acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.load) begin
      sum_d  = '0;
      cnt_d  = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      sq_vld_q <= 1'b0;
      scale_q  <= wrms_pkg::SCALE_RESET;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      sq_vld_q <= acc && !full;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sq_q <= mag * mag;
    end
  end

  // restoring divider, one quotient bit per step
  logic [CNT_W:0]   div_sh;
  logic [CNT_W+1:0] div_trial;
  logic             div_ge;

  assign div_sh    = {rem_q, quo_q[SUM_W-1]};
  assign div_trial = {1'b0, div_sh} - {2'b00, den_q};
  assign div_ge    = !div_trial[CNT_W+1];
  assign rem_d     = div_ge ? div_trial[CNT_W-1:0] : div_sh[CNT_W-1:0];
  assign quo_d     = {quo_q[SUM_W-2:0], div_ge};

  // digit-by-digit root, one root bit per step
  logic [SR_W+1:0] sq_sh;
  logic [SR_W+2:0] sq_trial;
  logic            sq_ge;

  assign sq_sh    = {srem_q, rad_q[SQ_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_sh} - (SR_W+3)'({root_q, 2'b01});
  assign sq_ge    = !sq_trial[SR_W+2];
  assign srem_d   = sq_ge ? sq_trial[SR_W-1:0] : sq_sh[SR_W-1:0];
  assign root_d   = {root_q[SB-2:0], sq_ge};
  assign rad_d    = {rad_q[SQ_W-3:0], 2'b00};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      den_q   <= cnt_q;
      quo_q   <= sum_add;
      rem_q   <= '0;
      empty_q <= (cnt_q == '0);
      dsnap_q <= drop_q;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.sq_load) begin
      rad_q  <= quo_q[SQ_W-1:0];
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q  <= rad_d;
      root_q <= root_d;
      srem_q <= srem_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(root_q) * PROD_W'(scale_q);
    end
  end

  // drop Q8.8 fraction, saturate
  logic [HI_W-1:0]  hi;
  logic [CMP_W-1:0] hi_ext;
  logic [wrms_pkg::RMS_W-1:0] rms_sat;

  assign hi      = prod_q[PROD_W-1:wrms_pkg::SCALE_FRAC];
  assign hi_ext  = CMP_W'(hi);
  assign rms_sat = (hi_ext > CMP_W'(wrms_pkg::RMS_MAX)) ? wrms_pkg::RMS_MAX
                                                        : hi_ext[wrms_pkg::RMS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rms_q   <= empty_q ? '0 : rms_sat;
      out_empty_q <= empty_q;
      out_drop_q  <= dsnap_q;
    end
  end

  assign in_ready_o     = cmd_i.accept_en;
  assign out_valid_o    = out_vld_q;
  assign out_rms_o      = out_rms_q;
  assign out_empty_o    = out_empty_q;
  assign out_dropped_o  = out_drop_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

endmodule

`default_nettype wire

[src/wrms_ctrl.sv]
// ----------------------------------------------------------------------------
// wrms_ctrl
// Report sequencer: divide, root, scale, output; empty window: output only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wrms_ctrl #(
  parameter int unsigned SAMPLE_BITS = wrms_pkg::SAMPLE_BITS,
  parameter int unsigned MAX_SAMPLES = wrms_pkg::MAX_SAMPLES
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  input  wire                      in_command_i,
  input  wire  wrms_pkg::wrms_sts_t sts_i,
  output wrms_pkg::wrms_cmd_t      cmd_o
);

  localparam int unsigned SUM_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_SAMPLES);
  localparam int unsigned ITER_W = $clog2(SUM_W);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SQLD = 6'b000100,
    ST_SQRT = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              report;

  assign report = (state_q == ST_IDLE) && in_valid_i &&
                  (in_command_i == wrms_pkg::CMD_REPORT);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept_en = 1'b1;
        if (report) begin
          cmd_o.load = 1'b1;
          iter_d     = ITER_W'(SUM_W - 1);
          state_d    = sts_i.cnt_zero ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = ST_SQLD;
        end
      end
      ST_SQLD: begin
        cmd_o.sq_load = 1'b1;
        iter_d        = ITER_W'(SAMPLE_BITS - 1);
        state_d       = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        iter_d        = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  `RMS_ASSERT(a_one_op, $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.sq_load, cmd_o.sq_step, cmd_o.mul, cmd_o.out_load}), "datapath got two operations at once")
  `RMS_ASSERT(a_out_free, cmd_o.out_load |-> sts_i.out_free, "result loaded over an unread one")
  `RMS_ASSERT_NEVER(a_busy_after_load, $past(cmd_o.load) && cmd_o.accept_en, "input reopened right after report")

endmodule

`default_nettype wire
